// ----- rtl/ovd_pkg.sv -----
// Shared types and constants for the oversampling decimator with leaky integrator.
// Used by every module in rtl/; depends on nothing else.
package ovd_pkg;

  // Sample width and the accumulator that sums up to 255 samples.
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned ACC_BITS    = SAMPLE_BITS + 8;
  localparam int unsigned WORD_BITS   = 16;
  localparam int unsigned SUM_BITS    = 32;

  // Configuration register indexes.
  localparam logic [1:0] REG_OVERSAMPLE = 2'd0;
  localparam logic [1:0] REG_DECIMATION = 2'd1;
  localparam logic [1:0] REG_FILTER     = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] OVERSAMPLE_RESET = 8'd64;
  localparam logic [3:0] DECIMATION_RESET = 4'd3;
  localparam logic [3:0] FILTER_RESET     = 4'd3;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [7:0] oversample_count;
    logic [3:0] decimation_shift;
    logic [3:0] filter_shift;
  } ovd_cfg_t;

  // One 16-bit word moving between stages, with its valid flag.
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] data;
  } ovd_word_t;

endpackage

// ----- rtl/ovd_fifo.sv -----
// Two-entry queue of 16-bit words, used between the stages and at the output.
// Depends on ovd_pkg for the word type.
module ovd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ovd_pkg::ovd_word_t wr_i,
  output logic              full_o,
  output ovd_pkg::ovd_word_t rd_o,
  input  logic              pop_i
);
  import ovd_pkg::*;

  logic [WORD_BITS-1:0] mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 do_push, do_pop;

  // Handshake qualification and pointer updates.
  always_comb begin
    do_push  = wr_i.valid && (cnt_q != 2'd2);
    do_pop   = pop_i && (cnt_q != 2'd0);
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage; the entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

  // The oldest entry is always presented.
  assign full_o     = (cnt_q == 2'd2);
  assign rd_o.valid = (cnt_q != 2'd0);
  assign rd_o.data  = mem_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue holds more than two items");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count did not grow on a write");
  a_cnt_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count did not shrink on a read");
`endif

endmodule

// ----- rtl/ovd_front.sv -----
// Front stage: counts and sums samples, and on the closing item emits the decimated value.
// Depends on ovd_pkg for widths, configuration and word types.
module ovd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ovd_pkg::ovd_cfg_t              cfg_i,
  input  logic                           accept_i,
  input  logic [ovd_pkg::SAMPLE_BITS-1:0] sample_i,
  output ovd_pkg::ovd_word_t             dec_o
);
  import ovd_pkg::*;

  logic [7:0]          cnt_q, cnt_d;
  logic [ACC_BITS-1:0] acc_q, acc_d;
  logic                emit;

  // Classify the item: either summed in, or closing the window.
  always_comb begin
    emit       = accept_i && (cnt_q >= cfg_i.oversample_count);
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    dec_o.valid = emit;
    dec_o.data  = WORD_BITS'(acc_q >> cfg_i.decimation_shift);
    if (emit) begin
      cnt_d = '0;
      acc_d = '0;
    end else if (accept_i) begin
      cnt_d = cnt_q + 8'd1;
      acc_d = acc_q + ACC_BITS'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (cnt_q == 8'd0 && acc_q == '0))
    else $error("window not cleared after emitting");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !emit) |=> (cnt_q == $past(cnt_q) + 8'd1))
    else $error("sample not counted");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> ($stable(cnt_q) && $stable(acc_q)))
    else $error("window changed without an item");
`endif

endmodule

// ----- rtl/ovd_back.sv -----
// Back stage: leaky integrator that turns decimated values into filtered results.
// Depends on ovd_pkg for widths and the word type.
module ovd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         filter_shift_i,
  input  ovd_pkg::ovd_word_t dec_i,
  output logic               pop_o,
  output ovd_pkg::ovd_word_t res_o,
  input  logic               res_full_i
);
  import ovd_pkg::*;

  logic [SUM_BITS-1:0] sum_q, sum_d;
  logic                step;

  // One integrator step per decimated value, when the output queue has room.
  always_comb begin
    step       = dec_i.valid && !res_full_i;
    sum_d      = sum_q + SUM_BITS'(dec_i.data) - (sum_q >> filter_shift_i);
    pop_o      = step;
    res_o.valid = step;
    res_o.data  = WORD_BITS'(sum_d >> filter_shift_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (step) begin
      sum_q <= sum_d;
    end
  end

endmodule

// ----- rtl/adc_oversample_decimate_leaky_filter_unit.sv -----
// Top level of the oversampling decimator with leaky integrator and its register block.
// Depends on ovd_pkg, ovd_front, ovd_fifo and ovd_back.
//
//   Channel    Handshake              Payload
//   sample     push_i / full_o        sample_i (10 bits)
//   result     pop_i / empty_o        filtered_value_o (16 bits)
//   config     cfg_valid_i / cfg_ready_o  cfg_index_i (2 bits), cfg_data_i (8 bits)
//
// One sample is taken every cycle while full_o is low. A closing item's decimated
// value is registered in the middle queue; when the result queue has room, the
// integrator writes its result straight into that queue, whose oldest entry
// is on the result ports. Both queues hold two items, so a stalled reader
// backs up into full_o only after two results and two decimated values wait.
// Reset clears the window, the integrator and the queues, and loads the
// register defaults; no initialisation pass is needed.
module adc_oversample_decimate_leaky_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [ovd_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [ovd_pkg::WORD_BITS-1:0]   filtered_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import ovd_pkg::*;

  ovd_cfg_t  cfg_q;
  ovd_word_t dec_word, mid_word, res_word, out_word;
  logic      mid_full, mid_pop, res_full, accept;

  // Register block; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oversample_count <= OVERSAMPLE_RESET;
      cfg_q.decimation_shift <= DECIMATION_RESET;
      cfg_q.filter_shift     <= FILTER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OVERSAMPLE: cfg_q.oversample_count <= cfg_data_i;
        REG_DECIMATION: cfg_q.decimation_shift <= cfg_data_i[3:0];
        REG_FILTER:     cfg_q.filter_shift     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign full_o = mid_full;
  assign accept = push_i && !mid_full;

  ovd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .sample_i (sample_i),
    .dec_o    (dec_word)
  );

  // Queue between the window stage and the integrator.
  ovd_fifo u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (dec_word),
    .full_o (mid_full),
    .rd_o   (mid_word),
    .pop_i  (mid_pop)
  );

  ovd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .filter_shift_i (cfg_q.filter_shift),
    .dec_i          (mid_word),
    .pop_o          (mid_pop),
    .res_o          (res_word),
    .res_full_i     (res_full)
  );

  // Result queue, presented on the output ports.
  ovd_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_word),
    .full_o (res_full),
    .rd_o   (out_word),
    .pop_i  (pop_i)
  );

  assign empty_o          = !out_word.valid;
  assign filtered_value_o = out_word.data;

endmodule
